FILE: design/multi_channel_countdown_timer_macros.svh
// Assertion macros shared by the countdown timer bank.
// Expects clk and rst_n in the scope of each use.
`ifndef MULTI_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH
`define MULTI_CHANNEL_COUNTDOWN_TIMER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MCCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by an outcome on the next edge.
`define MCCT_ASSERT_NEXT(label, cond, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> outcome) \
        else $error(msg);

`endif

FILE: design/mcct_pkg.sv
// Package for the countdown timer bank: widths, codes and the
// command and status structs between controller and datapath.
`default_nettype none

package mcct_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int MAX_WALK       = 16;

    localparam int KIND_W     = 2;
    localparam int IDX_W      = 4;
    localparam int TIME_W     = 32;
    localparam int ELAPSED_W  = 16;
    localparam int TIU_W      = 5;
    localparam int MASK_W     = 16;
    localparam int WALK_CNT_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [KIND_W-1:0] {
        KIND_START = 2'd0,
        KIND_STOP  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_QUERY = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMERS_IN_USE = 1'b0,
        REG_PERIODIC_MASK = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic do_start;
        logic do_stop;
        logic do_tick;
        logic do_query;
        logic walk_en;
        logic reply_load;
        logic flush_load;
    } dp_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic pend_vld;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: design/mcct_if.sv
// Valid/ready channel interfaces for input items and result items.
// Field widths come from mcct_pkg.
`default_nettype none

interface mcct_item_if;
    logic                           valid;
    logic                           ready;
    logic [mcct_pkg::KIND_W-1:0]    kind;
    logic [mcct_pkg::IDX_W-1:0]     timer_index;
    logic [mcct_pkg::TIME_W-1:0]    time_ms;
    logic [mcct_pkg::ELAPSED_W-1:0] elapsed_ms;

    modport source (output valid, kind, timer_index, time_ms, elapsed_ms, input ready);
    modport sink   (input valid, kind, timer_index, time_ms, elapsed_ms, output ready);
endinterface

interface mcct_result_if;
    logic                       valid;
    logic                       ready;
    logic                       is_expiry;
    logic [mcct_pkg::IDX_W-1:0] timer_index_res;
    logic                       running;
    logic                       last_of_run;

    modport source (output valid, is_expiry, timer_index_res, running, last_of_run,
                    input ready);
    modport sink   (input valid, is_expiry, timer_index_res, running, last_of_run,
                    output ready);
endinterface

`default_nettype wire

FILE: design/mcct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mcct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/mcct_ctrl.sv
// Controller of the countdown timer bank: input handshake and sequencing
// of start, stop, tick walk, query reply and final flush. Uses mcct_pkg.
`default_nettype none
`include "multi_channel_countdown_timer_macros.svh"

module mcct_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    input  wire logic [mcct_pkg::KIND_W-1:0] item_kind,
    output logic                             item_ready,
    output mcct_pkg::dp_cmd_t                cmd,
    input  wire mcct_pkg::dp_status_t        status
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_REPLY = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = (state_reg == ST_IDLE);
        accept     = item_valid && item_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (item_kind)
                        mcct_pkg::KIND_START: cmd.do_start = 1'b1;
                        mcct_pkg::KIND_STOP:  cmd.do_stop  = 1'b1;
                        mcct_pkg::KIND_TICK:
                        begin
                            cmd.do_tick = 1'b1;
                            state_next  = ST_WALK;
                        end
                        mcct_pkg::KIND_QUERY:
                        begin
                            cmd.do_query = 1'b1;
                            state_next   = ST_REPLY;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.walk_en = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_REPLY:
            begin
                if (status.out_free)
                begin
                    cmd.reply_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FLUSH:
            begin
                if (!status.pend_vld)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.flush_load = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MCCT_ASSERT(a_reply_needs_free_out, (cmd.reply_load |-> status.out_free), "reply into busy output")
    `MCCT_ASSERT_NEXT(a_tick_starts_walk, (accept && item_kind == mcct_pkg::KIND_TICK), (state_reg == ST_WALK), "tick did not start walk")
    `MCCT_ASSERT_NEXT(a_empty_flush_ends, (state_reg == ST_FLUSH && !status.pend_vld), (state_reg == ST_IDLE), "flush without pending did not end")

endmodule

`default_nettype wire

FILE: design/mcct_dp.sv
// Datapath of the countdown timer bank: configuration registers, running
// flags, time RAMs, walk pipeline, pending and output registers.
// Uses mcct_pkg and mcct_ram.
`default_nettype none
`include "multi_channel_countdown_timer_macros.svh"

module mcct_dp #(
    parameter int NUM_TIMERS = mcct_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mcct_pkg::dp_cmd_t                 cmd,
    output mcct_pkg::dp_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [mcct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mcct_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [mcct_pkg::IDX_W-1:0]        timer_index,
    input  wire logic [mcct_pkg::TIME_W-1:0]       time_ms,
    input  wire logic [mcct_pkg::ELAPSED_W-1:0]    elapsed_ms,
    input  wire logic                              out_ready,
    output logic                                   out_valid,
    output logic                                   is_expiry,
    output logic [mcct_pkg::IDX_W-1:0]             timer_index_res,
    output logic                                   running,
    output logic                                   last_of_run
);

    localparam int IW       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int WALK_MAX = (NUM_TIMERS < mcct_pkg::MAX_WALK) ? NUM_TIMERS
                                                                : mcct_pkg::MAX_WALK;
    localparam logic [mcct_pkg::WALK_CNT_W-1:0] WALK_MAX_C = mcct_pkg::WALK_CNT_W'(WALK_MAX);
    localparam logic [6:0] NUM_TIMERS_C = 7'(NUM_TIMERS);
    localparam int TW = mcct_pkg::TIME_W;
    localparam int EW = mcct_pkg::ELAPSED_W;
    localparam int XW = mcct_pkg::IDX_W;
    localparam int CW = mcct_pkg::WALK_CNT_W;

    // control registers
    logic [mcct_pkg::TIU_W-1:0]  tiu_reg, tiu_next;
    logic [mcct_pkg::MASK_W-1:0] mask_reg, mask_next;
    logic [NUM_TIMERS-1:0]       run_reg, run_next;
    logic [CW-1:0]               lim_reg, lim_next;
    logic [CW-1:0]               rd_cnt_reg, rd_cnt_next;
    logic                        ev_vld_reg, ev_vld_next;
    logic                        pend_vld_reg, pend_vld_next;
    logic                        out_vld_reg, out_vld_next;

    // payload registers
    logic [EW-1:0] el_reg, el_next;
    logic [XW-1:0] ev_idx_reg, ev_idx_next;
    logic [XW-1:0] q_idx_reg, q_idx_next;
    logic [XW-1:0] pend_idx_reg, pend_idx_next;
    logic          pend_run_reg, pend_run_next;
    logic          out_exp_reg, out_exp_next;
    logic [XW-1:0] out_idx_reg, out_idx_next;
    logic          out_run_reg, out_run_next;
    logic          out_last_reg, out_last_next;

    logic          item_ok, start_wr, q_ok, q_run;
    logic [IW-1:0] item_addr, rd_addr, rem_waddr;
    logic [TW-1:0] rem_rd, per_rd, rem_wdata, ev_sub, ev_left;
    logic          rem_we, rd_en, rd_more;
    logic          ev_run, ev_per, ev_ge, ev_exp, ev_fire, ev_go, stall, out_free;
    logic          load_push;
    logic [CW-1:0] lim_calc;

    assign item_ok   = {3'b000, timer_index} < NUM_TIMERS_C;
    assign item_addr = IW'(timer_index);
    assign start_wr  = cmd.do_start && item_ok;
    assign q_ok      = {3'b000, q_idx_reg} < NUM_TIMERS_C;
    assign q_run     = q_ok && run_reg[IW'(q_idx_reg)];
    assign lim_calc  = (CW'(tiu_reg) > WALK_MAX_C) ? WALK_MAX_C : CW'(tiu_reg);

    assign ev_run  = run_reg[IW'(ev_idx_reg)];
    assign ev_per  = mask_reg[ev_idx_reg];
    assign ev_ge   = rem_rd >= TW'(el_reg);
    assign ev_sub  = rem_rd - TW'(el_reg);
    assign ev_left = ev_ge ? ev_sub : rem_rd;
    assign ev_exp  = {1'b0, rem_rd} < {(TW - EW)'(0), el_reg, 1'b0};
    assign ev_fire = ev_vld_reg && ev_run && ev_exp;

    assign out_free  = !out_vld_reg || out_ready;
    assign stall     = ev_fire && pend_vld_reg && !out_free;
    assign ev_go     = ev_vld_reg && !stall;
    assign load_push = ev_go && ev_fire && pend_vld_reg;

    assign rd_more = rd_cnt_reg < lim_reg;
    assign rd_en   = cmd.walk_en && !stall && rd_more;
    assign rd_addr = IW'(rd_cnt_reg);

    assign rem_we    = start_wr || (ev_go && ev_run);
    assign rem_waddr = start_wr ? item_addr : IW'(ev_idx_reg);
    assign rem_wdata = start_wr ? time_ms : ((ev_exp && ev_per) ? per_rd : ev_left);

    mcct_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_TIMERS)
    ) u_rem_ram (
        .clk   (clk),
        .we    (rem_we),
        .waddr (rem_waddr),
        .wdata (rem_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rem_rd)
    );

    mcct_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_TIMERS)
    ) u_per_ram (
        .clk   (clk),
        .we    (start_wr),
        .waddr (item_addr),
        .wdata (time_ms),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (per_rd)
    );

    always_comb
    begin
        tiu_next      = tiu_reg;
        mask_next     = mask_reg;
        run_next      = run_reg;
        lim_next      = lim_reg;
        rd_cnt_next   = rd_cnt_reg;
        ev_vld_next   = ev_vld_reg;
        pend_vld_next = pend_vld_reg;
        out_vld_next  = out_vld_reg;
        el_next       = el_reg;
        ev_idx_next   = ev_idx_reg;
        q_idx_next    = q_idx_reg;
        pend_idx_next = pend_idx_reg;
        pend_run_next = pend_run_reg;
        out_exp_next  = out_exp_reg;
        out_idx_next  = out_idx_reg;
        out_run_next  = out_run_reg;
        out_last_next = out_last_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                mcct_pkg::REG_TIMERS_IN_USE: tiu_next  = cfg_data[mcct_pkg::TIU_W-1:0];
                mcct_pkg::REG_PERIODIC_MASK: mask_next = cfg_data;
                default: tiu_next = tiu_reg;
            endcase
        end

        if (start_wr)
        begin
            run_next[item_addr] = 1'b1;
        end
        if (cmd.do_stop && item_ok)
        begin
            run_next[item_addr] = 1'b0;
        end
        if (cmd.do_query)
        begin
            q_idx_next = timer_index;
        end

        if (cmd.do_tick)
        begin
            el_next       = elapsed_ms;
            lim_next      = lim_calc;
            rd_cnt_next   = '0;
            ev_vld_next   = 1'b0;
            pend_vld_next = 1'b0;
        end
        else if (!stall)
        begin
            ev_vld_next = rd_en;
            if (rd_en)
            begin
                ev_idx_next = rd_cnt_reg[XW-1:0];
                rd_cnt_next = rd_cnt_reg + CW'(1);
            end
        end

        // drop the flag of an expired one-shot timer, queue the expiry
        if (ev_go && ev_fire)
        begin
            if (!ev_per)
            begin
                run_next[IW'(ev_idx_reg)] = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_idx_next = ev_idx_reg;
            pend_run_next = ev_per;
        end

        if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        if (load_push)
        begin
            out_vld_next  = 1'b1;
            out_exp_next  = 1'b1;
            out_idx_next  = pend_idx_reg;
            out_run_next  = pend_run_reg;
            out_last_next = 1'b0;
        end
        else if (cmd.flush_load)
        begin
            out_vld_next  = 1'b1;
            out_exp_next  = 1'b1;
            out_idx_next  = pend_idx_reg;
            out_run_next  = pend_run_reg;
            out_last_next = 1'b1;
            pend_vld_next = 1'b0;
        end
        else if (cmd.reply_load)
        begin
            out_vld_next  = 1'b1;
            out_exp_next  = 1'b0;
            out_idx_next  = q_idx_reg;
            out_run_next  = q_run;
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tiu_reg      <= '0;
            mask_reg     <= '0;
            run_reg      <= '0;
            lim_reg      <= '0;
            rd_cnt_reg   <= '0;
            ev_vld_reg   <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            tiu_reg      <= tiu_next;
            mask_reg     <= mask_next;
            run_reg      <= run_next;
            lim_reg      <= lim_next;
            rd_cnt_reg   <= rd_cnt_next;
            ev_vld_reg   <= ev_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        el_reg       <= el_next;
        ev_idx_reg   <= ev_idx_next;
        q_idx_reg    <= q_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_run_reg <= pend_run_next;
        out_exp_reg  <= out_exp_next;
        out_idx_reg  <= out_idx_next;
        out_run_reg  <= out_run_next;
        out_last_reg <= out_last_next;
    end

    assign status.walk_done = !rd_more && !ev_vld_reg;
    assign status.pend_vld  = pend_vld_reg;
    assign status.out_free  = out_free;

    assign out_valid       = out_vld_reg;
    assign is_expiry       = out_exp_reg;
    assign timer_index_res = out_idx_reg;
    assign running         = out_run_reg;
    assign last_of_run     = out_last_reg;

    `MCCT_ASSERT(a_rd_cnt_in_range, (rd_cnt_reg <= lim_reg), "walk counter past limit")
    `MCCT_ASSERT(a_eval_in_walk, (ev_vld_reg |-> (CW'(ev_idx_reg) < lim_reg)), "evaluated timer outside walk")
    `MCCT_ASSERT_NEXT(a_flush_marks_last, cmd.flush_load, (out_vld_reg && out_last_reg), "flush did not mark last result")

endmodule

`default_nettype wire

FILE: design/multi_channel_countdown_timer.sv
// Bank of countdown timers with one-shot or periodic reload per timer.
// Channels: item (sink) takes start, stop, tick and query transactions;
// result (source) gives expiry and query answers. cfg_we/cfg_index/cfg_data
// write timers_in_use (index 0) and periodic_mask (index 1).
// Start and stop take effect in the cycle they are accepted; the block is
// ready again on the next cycle.
// Query: the answer is loaded into the output register once that register is
// free; the block is ready again after the answer is loaded.
// Tick: walks timers 0 .. N-1 (N = min(timers_in_use, NUM_TIMERS, 16)) one
// per cycle, unless stalled, through the time RAM read/write ports; the input
// is not ready again until the walk and the final flush are done. Each expiry is
// held in a pending register so the last one of a tick carries last_of_run;
// results appear while the walk is still running.
// A stalled result receiver holds the walk when a second expiry is ready
// and the output register is still full; no result is ever dropped.
// Reset clears all running flags and both configuration registers; period
// and remaining time stay undefined until a start writes them.
// Uses mcct_pkg, mcct_if, mcct_ctrl, mcct_dp and mcct_ram.
`default_nettype none

module multi_channel_countdown_timer #(
    parameter int NUM_TIMERS = mcct_pkg::NUM_TIMERS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    mcct_item_if.sink                            item,
    mcct_result_if.source                        result,
    input  wire logic                            cfg_we,
    input  wire logic [mcct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mcct_pkg::CFG_DATA_W-1:0] cfg_data
);

    mcct_pkg::dp_cmd_t    cmd;
    mcct_pkg::dp_status_t status;
    logic                 item_ready;

    assign item.ready = item_ready;

    mcct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_kind  (item.kind),
        .item_ready (item_ready),
        .cmd        (cmd),
        .status     (status)
    );

    mcct_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .timer_index     (item.timer_index),
        .time_ms         (item.time_ms),
        .elapsed_ms      (item.elapsed_ms),
        .out_ready       (result.ready),
        .out_valid       (result.valid),
        .is_expiry       (result.is_expiry),
        .timer_index_res (result.timer_index_res),
        .running         (result.running),
        .last_of_run     (result.last_of_run)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the countdown timer bank: directed and random
// start, stop, tick and query transactions scored against an in-bench timer model.
// Depends on mcct_pkg, mcct_if and multi_channel_countdown_timer.

module tb_top;

    localparam int IDLE_PCT      = 24;
    localparam int SETTLE_CYCLES = 32;
    localparam int PHASE_ITEMS   = 64;
    localparam int NT            = mcct_pkg::NUM_TIMERS_DEF;
    localparam int MW            = mcct_pkg::MAX_WALK;
    localparam int IW            = mcct_pkg::IDX_W;
    localparam int TW            = mcct_pkg::TIME_W;
    localparam int EW            = mcct_pkg::ELAPSED_W;
    localparam int DW            = mcct_pkg::CFG_DATA_W;

    typedef struct packed {
        mcct_pkg::kind_t kind;
        logic [IW-1:0]   idx;
        logic [TW-1:0]   tms;
        logic [EW-1:0]   el;
    } timer_cmd_t;

    typedef struct packed {
        logic          is_expiry;
        logic [IW-1:0] idx;
        logic          running;
        logic          last;
    } timer_event_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    mcct_pkg::cfg_reg_t cfg_index;
    logic [DW-1:0]      cfg_data;

    mcct_item_if   item ();
    mcct_result_if result ();

    multi_channel_countdown_timer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [TW-1:0]                   rem_ms  [NT];
    logic [TW-1:0]                   per_ms  [NT];
    logic                            run_flag [NT];
    logic [mcct_pkg::TIU_W-1:0]      tiu_reg;
    logic [mcct_pkg::MASK_W-1:0]     mask_reg;

    timer_cmd_t   cmd_queue [$];
    timer_event_t due_events [$];
    timer_cmd_t   sent_cmd;
    timer_event_t want_event;
    int           mismatch_count;
    bit           quiet;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void advance_timer_bank(timer_cmd_t c);
        int           walk;
        int           fired;
        timer_event_t ev;
        fired = 0;
        walk  = (tiu_reg > MW) ? MW : int'(tiu_reg);
        if (walk > NT)
            walk = NT;
        case (c.kind)
            mcct_pkg::KIND_START:
            begin
                per_ms[c.idx]   = c.tms;
                rem_ms[c.idx]   = c.tms;
                run_flag[c.idx] = 1'b1;
            end
            mcct_pkg::KIND_STOP:
                run_flag[c.idx] = 1'b0;
            mcct_pkg::KIND_QUERY:
            begin
                ev.is_expiry = 1'b0;
                ev.idx       = c.idx;
                ev.running   = run_flag[c.idx];
                ev.last      = 1'b1;
                due_events.push_back(ev);
            end
            default:
            begin
                for (int t = 0; t < walk; t++)
                begin
                    if (run_flag[t])
                    begin
                        if (rem_ms[t] >= TW'(c.el))
                            rem_ms[t] = rem_ms[t] - TW'(c.el);
                        if (rem_ms[t] < TW'(c.el))
                        begin
                            if (mask_reg[t])
                                rem_ms[t] = per_ms[t];
                            else
                                run_flag[t] = 1'b0;
                            ev.is_expiry = 1'b1;
                            ev.idx       = IW'(t);
                            ev.running   = run_flag[t];
                            ev.last      = 1'b0;
                            due_events.push_back(ev);
                            fired++;
                        end
                    end
                end
                if (fired > 0)
                    due_events[due_events.size()-1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void push_cmd(mcct_pkg::kind_t k, int idx, logic [TW-1:0] tms,
                                     logic [EW-1:0] el);
        timer_cmd_t c;
        c.kind = k;
        c.idx  = idx[IW-1:0];
        c.tms  = tms;
        c.el   = el;
        cmd_queue.push_back(c);
    endfunction

    task automatic flag_mismatch(string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic write_reg(mcct_pkg::cfg_reg_t r, logic [DW-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        if (r == mcct_pkg::REG_TIMERS_IN_USE)
            tiu_reg = v[mcct_pkg::TIU_W-1:0];
        else
            mask_reg = v[mcct_pkg::MASK_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_queue.size() != 0 || item.valid || due_events.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Driver: hold each transaction until accepted, then advance the model.
    always @(posedge clk)
    begin
        if (!rst_n)
            item.valid <= 1'b0;
        else
        begin
            if (item.valid && item.ready)
                advance_timer_bank(sent_cmd);
            if (!item.valid || item.ready)
            begin
                if (cmd_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    sent_cmd = cmd_queue.pop_front();
                    item.valid       <= 1'b1;
                    item.kind        <= sent_cmd.kind;
                    item.timer_index <= sent_cmd.idx;
                    item.time_ms     <= sent_cmd.tms;
                    item.elapsed_ms  <= sent_cmd.el;
                end
                else
                    item.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expected event.
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (result.valid && result.ready)
            begin
                if (due_events.size() == 0)
                    flag_mismatch($sformatf("unexpected result for timer %0d",
                                            result.timer_index_res));
                else
                begin
                    want_event = due_events.pop_front();
                    if (result.is_expiry !== want_event.is_expiry)
                        flag_mismatch($sformatf("is_expiry %b, want %b",
                                                result.is_expiry, want_event.is_expiry));
                    if (result.timer_index_res !== want_event.idx)
                        flag_mismatch($sformatf("timer_index_res %0d, want %0d",
                                                result.timer_index_res, want_event.idx));
                    if (result.running !== want_event.running)
                        flag_mismatch($sformatf("running %b, want %b (timer %0d)",
                                                result.running, want_event.running,
                                                want_event.idx));
                    if (result.last_of_run !== want_event.last)
                        flag_mismatch($sformatf("last_of_run %b, want %b (timer %0d)",
                                                result.last_of_run, want_event.last,
                                                want_event.idx));
                end
            end
            result.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int            walk;
        int            pick;
        int            idx;
        logic [TW-1:0] tms;
        logic [EW-1:0] el;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = mcct_pkg::REG_TIMERS_IN_USE;
        cfg_data         = '0;
        item.valid       = 1'b0;
        item.kind        = mcct_pkg::KIND_START;
        item.timer_index = '0;
        item.time_ms     = '0;
        item.elapsed_ms  = '0;
        result.ready     = 1'b0;
        sent_cmd         = '0;
        tiu_reg          = '0;
        mask_reg         = '0;
        quiet            = 1'b0;
        mismatch_count   = 0;
        for (int t = 0; t < NT; t++)
        begin
            run_flag[t] = 1'b0;
            rem_ms[t]   = '0;
            per_ms[t]   = '0;
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'd4);
        write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'h0005);
        push_cmd(mcct_pkg::KIND_QUERY, 0, 32'd0, 16'd0);
        push_cmd(mcct_pkg::KIND_START, 0, 32'd10, 16'd0);
        push_cmd(mcct_pkg::KIND_START, 1, 32'd5, 16'hFFFF);
        push_cmd(mcct_pkg::KIND_START, 2, 32'd0, 16'd0);
        push_cmd(mcct_pkg::KIND_START, 3, 32'hFFFF_FFFF, 16'd0);
        push_cmd(mcct_pkg::KIND_QUERY, 1, 32'hFFFF_FFFF, 16'd0);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd0);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd5);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'hFFFF);
        push_cmd(mcct_pkg::KIND_STOP, 3, 32'd0, 16'd0);
        push_cmd(mcct_pkg::KIND_QUERY, 3, 32'd0, 16'd0);
        push_cmd(mcct_pkg::KIND_START, 15, 32'd3, 16'd0);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd7);
        push_cmd(mcct_pkg::KIND_QUERY, 15, 32'd0, 16'd0);
        push_cmd(mcct_pkg::KIND_QUERY, 2, 32'd0, 16'd0);
        drain();

        write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'd16);
        write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'hFFFF);
        push_cmd(mcct_pkg::KIND_START, 7, 32'd2, 16'd0);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd1);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd1);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd3);
        push_cmd(mcct_pkg::KIND_STOP, 15, 32'd0, 16'd0);
        drain();

        write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'd31);
        write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'h0000);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd2);
        push_cmd(mcct_pkg::KIND_QUERY, 7, 32'd0, 16'd0);
        drain();

        write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'd0);
        push_cmd(mcct_pkg::KIND_TICK, 0, 32'd0, 16'd9);
        push_cmd(mcct_pkg::KIND_QUERY, 0, 32'd0, 16'd0);
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            quiet = (phase == 2);
            case (phase)
                0:
                begin
                    write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'd16);
                    write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'hFFFF);
                end
                1:
                begin
                    write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'($urandom_range(1, 16)));
                    write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'($urandom_range(0, 65535)));
                end
                2:
                begin
                    write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'd16);
                    write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'($urandom_range(0, 65535)));
                end
                3:
                begin
                    write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'($urandom_range(0, 31)));
                    write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'h0000);
                end
                default:
                begin
                    write_reg(mcct_pkg::REG_TIMERS_IN_USE, 16'($urandom_range(0, 16)));
                    write_reg(mcct_pkg::REG_PERIODIC_MASK, 16'($urandom_range(0, 65535)));
                end
            endcase
            walk = (tiu_reg > MW) ? MW : int'(tiu_reg);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick = $urandom_range(99);
                if (walk != 0 && $urandom_range(1) == 1)
                    idx = $urandom_range(walk - 1);
                else
                    idx = $urandom_range(NT - 1);
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5: tms = $urandom_range(0, 40);
                    6, 7:             tms = $urandom_range(0, 1000);
                    default:          tms = $urandom();
                endcase
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5, 6: el = EW'($urandom_range(0, 12));
                    7, 8:                el = EW'($urandom_range(0, 300));
                    default:             el = EW'($urandom_range(0, 65535));
                endcase
                if (pick < 30)
                    push_cmd(mcct_pkg::KIND_START, idx, tms, el);
                else if (pick < 40)
                    push_cmd(mcct_pkg::KIND_STOP, idx, tms, el);
                else if (pick < 80)
                    push_cmd(mcct_pkg::KIND_TICK, idx, tms, el);
                else
                    push_cmd(mcct_pkg::KIND_QUERY, idx, tms, el);
            end
            drain();
        end

        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule
